[hdl/nsv_pkg.sv]
// Package for the NMEA sentence validator: character codes, status codes
// and the verdict record passed between the parser and the top level.
// No dependencies.
`default_nettype none

package nsv_pkg;

	// Characters with a role in the sentence grammar
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// Most letters or digits allowed after the two talker letters
	localparam logic [2:0] ADDR_MAX = 3'd5;

	// Verdict status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_MALFORM  = 2'd1;
	localparam logic [1:0] STATUS_MISMATCH = 2'd2;

	// One verdict per line
	typedef struct packed {
		logic       sentence_ok;
		logic [1:0] status;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
	} verdict_t;

endpackage

`default_nettype wire

[hdl/nsv_stream_if.sv]
// Valid/ready channel interfaces: received bytes in, line verdicts out.
// Depends on nothing.
`default_nettype none

interface nsv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsv_verdict_if;
	logic       valid;
	logic       ready;
	logic       sentence_ok;
	logic [1:0] status;
	logic [7:0] computed_sum;
	logic [7:0] received_sum;

	modport source (output valid, output sentence_ok, output status,
		output computed_sum, output received_sum, input ready);
	modport sink   (input valid, input sentence_ok, input status,
		input computed_sum, input received_sum, output ready);
endinterface

`default_nettype wire

[hdl/nmea_sentence_validator.sv]
// NMEA 0183 sentence validator top level: input register, line parser and
// verdict register. Uses nsv_pkg, nsv_stream_if.sv and nsv_line_parser.
//
// Usage:
//   rx      byte stream in (valid/ready), one ASCII byte per transaction.
//   verdict one transaction per line ended by CR LF: sentence_ok, status
//           (0 ok, 1 malformed, 2 checksum mismatch), computed_sum and
//           received_sum (both zero on a malformed line).
//   Throughput is one byte per cycle; rx.ready stays high while the
//   verdict register is free or being drained.
//   A line end passes through the input register; the parser result
//   for the LF loads the verdict register when that byte advances
//   out of the input register.
//   If the receiver stalls with a verdict held, bytes that give no verdict
//   still flow; the next line end waits in the input register and rx.ready
//   drops until the held verdict is taken.
//   Reset clears the input and verdict valid flags and returns the parser
//   to the start of a line with zero checksum.
`default_nettype none

module nmea_sentence_validator (
	input  wire logic   clk,
	input  wire logic   arst_n,
	nsv_byte_if.sink    rx,
	nsv_verdict_if.source verdict
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              has_result;
	nsv_pkg::verdict_t result;
	logic              out_valid_q;
	nsv_pkg::verdict_t out_q;

	nsv_line_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (advance),
		.rx_byte    (byte_s1),
		.has_result (has_result),
		.result     (result)
	);

	// The byte in the input register moves on unless its verdict finds the
	// output register full and stalled
	assign advance  = valid_s1 && (!has_result || !out_valid_q || verdict.ready);
	assign rx.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) byte_s1 <= rx.rx_byte;
	end

	// Verdict register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) out_q <= result;
	end

	assign verdict.valid        = out_valid_q;
	assign verdict.sentence_ok  = out_q.sentence_ok;
	assign verdict.status       = out_q.status;
	assign verdict.computed_sum = out_q.computed_sum;
	assign verdict.received_sum = out_q.received_sum;

	// A byte held in the input register is not lost or changed
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("held input byte changed");

	// A verdict is only written over a free or drained register
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_result) |-> (!out_valid_q || verdict.ready))
		else $error("verdict register overwritten");

	// The input stalls only behind a full verdict register
	assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (out_valid_q && !verdict.ready && has_result))
		else $error("input stalled without cause");

endmodule

`default_nettype wire

[hdl/nsv_line_parser.sv]
// Line parser: holds the grammar phase, running XOR and hex digits of the
// current line and decides the verdict at CR LF. Uses nsv_pkg.
`default_nettype none

module nsv_line_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            byte_en,
	input  wire logic [7:0]      rx_byte,
	output logic                 has_result,
	output nsv_pkg::verdict_t    result
);

	typedef enum logic [3:0] {
		PH_START, PH_TALK1, PH_TALK2, PH_ADDR, PH_DATA,
		PH_HEX1, PH_HEX2, PH_END, PH_BAD
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [2:0] addr_cnt;
		logic [7:0] run_xor;
		logic [7:0] hex_val;
		logic       cr_pending;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		phase: PH_START, addr_cnt: 3'd0, run_xor: 8'd0, hex_val: 8'd0,
		cr_pending: 1'b0};

	line_state_t st_q;
	line_state_t st_mid;
	line_state_t st_d;

	function automatic logic is_letter(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	// Hex digit value in [3:0], valid flag in [4]
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (is_digit(c)) begin
			v = c - 8'h30;
			return {1'b1, v[3:0]};
		end
		if (c inside {[8'h41:8'h46]}) begin
			v = c - 8'h37;
			return {1'b1, v[3:0]};
		end
		if (c inside {[8'h61:8'h66]}) begin
			v = c - 8'h57;
			return {1'b1, v[3:0]};
		end
		return 5'd0;
	endfunction

	// One content byte through the grammar
	function automatic line_state_t take(input line_state_t s, input logic [7:0] c);
		line_state_t n;
		logic [4:0]  d;
		n = s;
		d = hex_digit(c);
		case (s.phase)
			PH_START: begin
				n.phase = (c == nsv_pkg::CH_DOLLAR) ? PH_TALK1 : PH_BAD;
			end
			PH_TALK1, PH_TALK2: begin
				if (is_letter(c)) begin
					n.run_xor = s.run_xor ^ c;
					if (s.phase == PH_TALK1) begin
						n.phase = PH_TALK2;
					end else begin
						n.phase    = PH_ADDR;
						n.addr_cnt = 3'd0;
					end
				end else begin
					n.phase = PH_BAD;
				end
			end
			PH_ADDR: begin
				if ((is_letter(c) || is_digit(c)) && s.addr_cnt < nsv_pkg::ADDR_MAX) begin
					n.run_xor  = s.run_xor ^ c;
					n.addr_cnt = s.addr_cnt + 3'd1;
				end else if (c == nsv_pkg::CH_COMMA && s.addr_cnt != 3'd0) begin
					n.run_xor = s.run_xor ^ c;
					n.phase   = PH_DATA;
				end else begin
					n.phase = PH_BAD;
				end
			end
			PH_DATA: begin
				if (c == nsv_pkg::CH_STAR) n.phase = PH_HEX1;
				else n.run_xor = s.run_xor ^ c;
			end
			PH_HEX1, PH_HEX2: begin
				if (d[4]) begin
					n.hex_val = {s.hex_val[3:0], d[3:0]};
					n.phase   = (s.phase == PH_HEX1) ? PH_HEX2 : PH_END;
				end else begin
					n.phase = PH_BAD;
				end
			end
			default: begin
				n.phase = PH_BAD;
			end
		endcase
		return n;
	endfunction

	// Next state and verdict for the byte in hand
	always_comb begin
		has_result = 1'b0;
		result     = '{sentence_ok: 1'b0, status: nsv_pkg::STATUS_MALFORM,
			computed_sum: 8'd0, received_sum: 8'd0};
		st_mid     = st_q;
		st_d       = st_q;
		if (st_q.cr_pending && rx_byte == nsv_pkg::CH_LF) begin
			has_result = 1'b1;
			if (st_q.phase == PH_END) begin
				result.sentence_ok  = (st_q.run_xor == st_q.hex_val);
				result.status       = (st_q.run_xor == st_q.hex_val) ?
					nsv_pkg::STATUS_OK : nsv_pkg::STATUS_MISMATCH;
				result.computed_sum = st_q.run_xor;
				result.received_sum = st_q.hex_val;
			end
			st_d = LINE_CLEAR;
		end else begin
			// a CR that was not followed by LF is plain content
			if (st_q.cr_pending) st_mid = take(st_q, nsv_pkg::CH_CR);
			st_mid.cr_pending = 1'b0;
			if (rx_byte == nsv_pkg::CH_CR) begin
				st_d            = st_mid;
				st_d.cr_pending = 1'b1;
			end else begin
				st_d = take(st_mid, rx_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LINE_CLEAR;
		end else if (byte_en) begin
			st_q <= st_d;
		end
	end

	// A verdict only ever closes a CR LF pair
	assert property (@(posedge clk) disable iff (!arst_n)
		has_result |-> st_q.cr_pending)
		else $error("verdict without a pending CR");

	// A line end leaves a fresh line behind
	assert property (@(posedge clk) disable iff (!arst_n)
		(byte_en && has_result) |=> (st_q.phase == PH_START && st_q.run_xor == 8'd0
			&& st_q.hex_val == 8'd0 && !st_q.cr_pending))
		else $error("line state not cleared after verdict");

	// Malformed verdicts carry zero sums
	assert property (@(posedge clk) disable iff (!arst_n)
		(has_result && result.status == nsv_pkg::STATUS_MALFORM)
			|-> (result.computed_sum == 8'd0 && result.received_sum == 8'd0))
		else $error("malformed verdict with nonzero sums");

	// The ok flag and the status code agree
	assert property (@(posedge clk) disable iff (!arst_n)
		has_result |-> (result.sentence_ok == (result.status == nsv_pkg::STATUS_OK)))
		else $error("ok flag disagrees with status");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for nmea_sentence_validator: drives byte streams of NMEA
// lines and checks every line verdict against a built-in line parser model.
// Depends on nsv_pkg, nsv_byte_if / nsv_verdict_if and the validator RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Position in the sentence grammar, as tracked by the predictor
	typedef enum logic [3:0] {
		LN_DOLLAR, LN_TALKER0, LN_TALKER1, LN_ADDRESS, LN_FIELDS,
		LN_HEX_HI, LN_HEX_LO, LN_CHECKED, LN_BAD
	} line_phase_t;

	logic clk;
	logic arst_n;

	nsv_byte_if    rx_if ();
	nsv_verdict_if vd_if ();

	nmea_sentence_validator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_if),
		.verdict (vd_if)
	);

	// Predictor state
	line_phase_t ln_phase;
	logic [2:0]  addr_cnt;
	logic [7:0]  sum_acc;
	logic [7:0]  hex_acc;
	logic        cr_held;

	nsv_pkg::verdict_t expected_verdicts[$];
	logic [7:0]        line_buf[$];

	// Run control and statistics
	bit tx_gaps_on;
	bit rx_gaps_on;
	int hold_request;
	int stall_left;
	int rx_gap_left;
	int fails;
	int bytes_sent;
	int rx_stall_cycles;
	int verdicts_checked;
	int status_seen[3];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	//----------------------------------------------------------------
	// Predictor
	//----------------------------------------------------------------
	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// Nibble value of a hex digit; bit 4 set when c is not one
	function automatic logic [4:0] hex_nibble(logic [7:0] c);
		if (is_num(c)) return 5'(c - "0");
		if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
		if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
		return 5'd16;
	endfunction

	function automatic void restart_line();
		ln_phase = LN_DOLLAR;
		addr_cnt = 3'd0;
		sum_acc  = 8'h00;
		hex_acc  = 8'h00;
		cr_held  = 1'b0;
	endfunction

	// Advance the grammar by one content byte
	function automatic void take_char(logic [7:0] c);
		logic [4:0] nib;
		case (ln_phase)
			LN_DOLLAR: ln_phase = (c == nsv_pkg::CH_DOLLAR) ? LN_TALKER0 : LN_BAD;
			LN_TALKER0, LN_TALKER1: begin
				if (is_alpha(c)) begin
					sum_acc ^= c;
					if (ln_phase == LN_TALKER0) begin
						ln_phase = LN_TALKER1;
					end else begin
						ln_phase = LN_ADDRESS;
						addr_cnt = 3'd0;
					end
				end else begin
					ln_phase = LN_BAD;
				end
			end
			LN_ADDRESS: begin
				if ((is_alpha(c) || is_num(c)) && addr_cnt < nsv_pkg::ADDR_MAX) begin
					sum_acc ^= c;
					addr_cnt++;
				end else if (c == nsv_pkg::CH_COMMA && addr_cnt >= 3'd1) begin
					sum_acc ^= c;
					ln_phase = LN_FIELDS;
				end else begin
					ln_phase = LN_BAD;
				end
			end
			LN_FIELDS: begin
				if (c == nsv_pkg::CH_STAR) ln_phase = LN_HEX_HI;
				else sum_acc ^= c;
			end
			LN_HEX_HI, LN_HEX_LO: begin
				nib = hex_nibble(c);
				if (!nib[4]) begin
					hex_acc = {hex_acc[3:0], nib[3:0]};
					ln_phase = (ln_phase == LN_HEX_HI) ? LN_HEX_LO : LN_CHECKED;
				end else begin
					ln_phase = LN_BAD;
				end
			end
			default: ln_phase = LN_BAD;
		endcase
	endfunction

	// One accepted byte; a CR LF pair queues the verdict of the line
	function automatic void predict_byte(logic [7:0] c);
		nsv_pkg::verdict_t v;
		if (cr_held) begin
			cr_held = 1'b0;
			if (c == nsv_pkg::CH_LF) begin
				v = '0;
				if (ln_phase == LN_CHECKED) begin
					v.sentence_ok  = (sum_acc == hex_acc);
					v.status       = v.sentence_ok ? nsv_pkg::STATUS_OK :
						nsv_pkg::STATUS_MISMATCH;
					v.computed_sum = sum_acc;
					v.received_sum = hex_acc;
				end else begin
					v.status = nsv_pkg::STATUS_MALFORM;
				end
				expected_verdicts.push_back(v);
				restart_line();
				return;
			end
			// lone CR is ordinary content
			take_char(nsv_pkg::CH_CR);
		end
		if (c == nsv_pkg::CH_CR) cr_held = 1'b1;
		else take_char(c);
	endfunction

	//----------------------------------------------------------------
	// Random helpers
	//----------------------------------------------------------------
	// Mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_alnum();
		if ($urandom_range(2) == 0) return 8'("0" + $urandom_range(9));
		return rand_letter();
	endfunction

	// Field content: mostly printable, some raw bytes, never the star
	function automatic logic [7:0] rand_field_byte();
		logic [7:0] b;
		if ($urandom_range(99) < 85) b = 8'($urandom_range(8'h20, 8'h7E));
		else b = 8'($urandom_range(255));
		if (b == nsv_pkg::CH_STAR) b = "#";
		return b;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
		if (n < 4'd10) return "0" + n;
		return 8'((lower ? "a" : "A") + n - 10);
	endfunction

	//----------------------------------------------------------------
	// Line building
	//----------------------------------------------------------------
	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	// XOR of everything after the leading dollar
	function automatic logic [7:0] buf_xor();
		logic [7:0] x;
		x = 8'h00;
		for (int i = 1; i < line_buf.size(); i++) x ^= line_buf[i];
		return x;
	endfunction

	// Star and two hex digits; a bad sum is off by a fixed pattern
	function automatic void close_sentence(bit good, bit lower);
		logic [7:0] s;
		s = buf_xor();
		if (!good) s ^= 8'h5A;
		line_buf.push_back(nsv_pkg::CH_STAR);
		line_buf.push_back(hex_char(s[7:4], lower));
		line_buf.push_back(hex_char(s[3:0], lower));
	endfunction

	// Random sentence up to the star, with the given address length
	function automatic void build_sentence(int addr_len);
		int n;
		line_buf.delete();
		line_buf.push_back(nsv_pkg::CH_DOLLAR);
		line_buf.push_back(rand_letter());
		line_buf.push_back(rand_letter());
		repeat (addr_len) line_buf.push_back(rand_alnum());
		line_buf.push_back(nsv_pkg::CH_COMMA);
		n = $urandom_range(0, 12);
		repeat (n) begin
			if ($urandom_range(19) == 0) line_buf.push_back(nsv_pkg::CH_CR);
			else if ($urandom_range(19) == 0) line_buf.push_back(nsv_pkg::CH_LF);
			else line_buf.push_back(rand_field_byte());
		end
	endfunction

	//----------------------------------------------------------------
	// Byte source
	//----------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) begin
			rx_stall_cycles++;
			@(posedge clk);
		end
		predict_byte(b);
		bytes_sent++;
	endtask

	// Terminate the buffered line with CR LF and send it
	task automatic send_line();
		line_buf.push_back(nsv_pkg::CH_CR);
		line_buf.push_back(nsv_pkg::CH_LF);
		foreach (line_buf[i]) send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	//----------------------------------------------------------------
	// Verdict sink: checks each transaction, drives ready
	//----------------------------------------------------------------
	task automatic check_verdict();
		nsv_pkg::verdict_t want;
		nsv_pkg::verdict_t got;
		got.sentence_ok  = vd_if.sentence_ok;
		got.status       = vd_if.status;
		got.computed_sum = vd_if.computed_sum;
		got.received_sum = vd_if.received_sum;
		if (expected_verdicts.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("%t: verdict with none pending: ok=%b status=%0d sum=%02h rcv=%02h",
					$realtime, got.sentence_ok, got.status, got.computed_sum,
					got.received_sum);
			return;
		end
		want = expected_verdicts.pop_front();
		verdicts_checked++;
		if (want.status <= nsv_pkg::STATUS_MISMATCH) status_seen[want.status]++;
		if (got.sentence_ok !== want.sentence_ok || got.status !== want.status ||
				got.computed_sum !== want.computed_sum ||
				got.received_sum !== want.received_sum) begin
			fails++;
			if (fails <= 10) begin
				$display("%t: verdict %0d wrong: exp ok=%b status=%0d sum=%02h rcv=%02h,",
					$realtime, verdicts_checked, want.sentence_ok, want.status,
					want.computed_sum, want.received_sum);
				$display("    got ok=%b status=%0d sum=%02h rcv=%02h",
					got.sentence_ok, got.status, got.computed_sum, got.received_sum);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && vd_if.valid && vd_if.ready) check_verdict();
		// a long hold-off requested by a test is counted down here
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			vd_if.ready <= 1'b0;
		end else if (rx_gap_left > 0) begin
			rx_gap_left--;
			vd_if.ready <= 1'b0;
		end else begin
			vd_if.ready <= 1'b1;
			if (rx_gaps_on && $urandom_range(99) < 30) rx_gap_left = pick_gap();
		end
	end

	//----------------------------------------------------------------
	// Tests
	//----------------------------------------------------------------
	// Grammar edges, checksum extremes and line-end corner cases
	task automatic test_directed();
		push_text("$GPGGA,1,2");
		close_sentence(1'b1, 1'b0);
		send_line();
		// lower-case talker and hex, wrong sum
		push_text("$gpxx1,");
		close_sentence(1'b0, 1'b1);
		send_line();
		// empty line
		send_line();
		// five address characters, then six
		push_text("$AB12345,x");
		close_sentence(1'b1, 1'b0);
		send_line();
		push_text("$AB123456,x");
		close_sentence(1'b1, 1'b0);
		send_line();
		// no address character, then no comma
		push_text("$AB,x*00");
		send_line();
		push_text("$AB1x*00");
		send_line();
		// lone CR and lone LF inside the fields
		push_text("$AB1,a");
		line_buf.push_back(nsv_pkg::CH_CR);
		push_text("b");
		line_buf.push_back(nsv_pkg::CH_LF);
		push_text("c");
		close_sentence(1'b1, 1'b0);
		send_line();
		// raw zero and all-ones bytes in the fields
		push_text("$ZZ9,");
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		line_buf.push_back(8'h80);
		close_sentence(1'b1, 1'b1);
		send_line();
		// checksum of zero and of all ones
		push_text("$AB1,");
		line_buf.push_back(buf_xor());
		close_sentence(1'b1, 1'b0);
		send_line();
		push_text("$AB1,");
		line_buf.push_back(buf_xor() ^ 8'hFF);
		close_sentence(1'b1, 1'b0);
		send_line();
		// trailing byte after the hex digits
		push_text("$AB1,");
		close_sentence(1'b1, 1'b0);
		push_text("Z");
		send_line();
		// one hex digit, then a non-hex digit
		push_text("$AB1,*4");
		send_line();
		push_text("$AB1,*4G");
		send_line();
		// no dollar, digit in the talker
		push_text("GPAB1,*00");
		send_line();
		push_text("$1B1,*00");
		send_line();
		// CR CR LF: the first CR becomes trailing content
		push_text("$AB1,");
		close_sentence(1'b1, 1'b0);
		line_buf.push_back(nsv_pkg::CH_CR);
		send_line();
		// long malformed line
		repeat (40) line_buf.push_back("~");
		push_text("$AB1,*00");
		send_line();
	endtask

	// Verdict sink holds off while lines keep coming back to back
	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		hold_request = 300;
		repeat (10) begin
			build_sentence($urandom_range(1, 5));
			close_sentence($urandom_range(3) != 0, 1'($urandom_range(1)));
			send_line();
		end
		tx_gaps_on = 1'b1;
	endtask

	// Mostly well-formed sentences with random content, plus broken ones
	task automatic test_random_lines();
		int lines;
		int first;
		int k;
		lines = 0;
		first = bytes_sent;
		while (bytes_sent - first < 280 || lines < 12) begin
			if ($urandom_range(7) == 0) tx_gaps_on = ($urandom_range(3) != 0);
			if ($urandom_range(7) == 0) rx_gaps_on = ($urandom_range(3) != 0);
			if ($urandom_range(99) < 70) begin
				build_sentence($urandom_range(1, 5));
				close_sentence($urandom_range(3) != 0, 1'($urandom_range(1)));
			end else begin
				build_sentence($urandom_range(1, 5));
				close_sentence(1'($urandom_range(1)), 1'($urandom_range(1)));
				case ($urandom_range(4))
					0: line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
					1: begin
						k = $urandom_range(line_buf.size() - 2);
						line_buf = line_buf[0:k];
					end
					2: line_buf.push_back(rand_alnum());
					3: begin
						line_buf.delete();
						k = $urandom_range(0, 50);
						repeat (k) line_buf.push_back(8'($urandom_range(255)));
					end
					default: begin
						build_sentence($urandom_range(1) ? 0 : $urandom_range(6, 7));
						close_sentence(1'b1, 1'b0);
					end
				endcase
			end
			send_line();
			lines++;
		end
	endtask

	//----------------------------------------------------------------
	// Sequence
	//----------------------------------------------------------------
	initial begin
		int drain;
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = 8'h00;
		vd_if.ready   = 1'b0;
		tx_gaps_on    = 1'b1;
		rx_gaps_on    = 1'b1;
		restart_line();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_backpressure();
		test_random_lines();

		rx_if.valid <= 1'b0;
		drain = 0;
		while (expected_verdicts.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		// allow for stray verdicts after the queue drains
		repeat (8) @(posedge clk);
		if (expected_verdicts.size() != 0) begin
			$display("%0d expected verdicts never arrived", expected_verdicts.size());
			fails += expected_verdicts.size();
		end

		$display("Covered %0d bytes and %0d verdicts: %0d ok, %0d malformed, %0d bad checksum",
			bytes_sent, verdicts_checked, status_seen[nsv_pkg::STATUS_OK],
			status_seen[nsv_pkg::STATUS_MALFORM], status_seen[nsv_pkg::STATUS_MISMATCH]);
		$display("Byte input was held off for %0d cycles by verdict backpressure",
			rx_stall_cycles);
		if (fails == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d failures", fails);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[nmea_sentence_validator.f]
hdl/nsv_pkg.sv
hdl/nsv_stream_if.sv
hdl/nsv_line_parser.sv
hdl/nmea_sentence_validator.sv
dv/testbench.sv
